### rtl/psre_pkg.sv
`timescale 1ns / 1ps

package psre_pkg;

    localparam int MAX_ROWS   = 512;
    localparam int MAX_COLS   = 512;
    localparam int MAX_RADIUS = 7;
    localparam int DEPTH_BITS = 16;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int RAD_W   = 3;
    localparam int SPAN_W  = RAD_W + 1;
    localparam int CFG_W   = 10;
    localparam int POS_W   = 10;
    localparam int CRD_W   = POS_W + 2;
    localparam int SUM_W   = DEPTH_BITS + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = 32;
    localparam int QUO_W   = SUM_W + FRAC_W;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int CIDX_W  = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_COLS   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] min_row;
        logic [POS_W-1:0] min_col;
        logic [POS_W-1:0] max_row;
        logic [POS_W-1:0] max_col;
        logic [RAD_W-1:0] radius;
        logic [ROW_W-1:0] rows_m1;
        logic [COL_W-1:0] cols_m1;
    } patch_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              done;
        logic [SUM_W-1:0]  sum_min;
        logic [SUM_W-1:0]  sum_max;
    } patch_rsp_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] numer;
        logic [SUM_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] ratio;
        logic               zero_divisor;
    } div_rsp_t;

endpackage

### rtl/psre_ram.sv
`timescale 1ns / 1ps

module psre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/psre_patch.sv
`timescale 1ns / 1ps

module psre_patch
    import psre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  patch_req_t            req,
    input  logic [DEPTH_BITS-1:0] rd_data,
    output patch_rsp_t            rsp
);

    logic              busy_reg;
    logic              patch_reg;
    logic [SPAN_W-1:0] si_reg;
    logic [SPAN_W-1:0] ti_reg;
    logic              rd_valid_reg;
    logic              rd_patch_reg;
    logic              rd_last_reg;
    logic              done_reg;
    logic [POS_W-1:0]  min_row_reg;
    logic [POS_W-1:0]  min_col_reg;
    logic [POS_W-1:0]  max_row_reg;
    logic [POS_W-1:0]  max_col_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROW_W-1:0]  rows_m1_reg;
    logic [COL_W-1:0]  cols_m1_reg;
    logic [SUM_W-1:0]  sum_reg [2];

    logic [POS_W-1:0]  row_pos;
    logic [POS_W-1:0]  col_pos;
    logic [CRD_W-1:0]  row_c;
    logic [CRD_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_idx;
    logic [COL_W-1:0]  col_idx;
    logic [SPAN_W-1:0] span;
    logic              last_t;
    logic              last_s;
    logic              last_read;

    always_comb
    begin
        row_pos = patch_reg ? max_row_reg : min_row_reg;
        col_pos = patch_reg ? max_col_reg : min_col_reg;
        span    = {rad_reg, 1'b0};

        // Position is 1-based; the patch starts radius steps before it.
        row_c = {2'b00, row_pos} + {{(CRD_W-SPAN_W){1'b0}}, si_reg}
              - {{(CRD_W-RAD_W){1'b0}}, rad_reg} - CRD_W'(1);
        col_c = {2'b00, col_pos} + {{(CRD_W-SPAN_W){1'b0}}, ti_reg}
              - {{(CRD_W-RAD_W){1'b0}}, rad_reg} - CRD_W'(1);

        if (row_c[CRD_W-1])
        begin
            row_idx = '0;
        end
        else if (row_c > {{(CRD_W-ROW_W){1'b0}}, rows_m1_reg})
        begin
            row_idx = rows_m1_reg;
        end
        else
        begin
            row_idx = row_c[ROW_W-1:0];
        end

        if (col_c[CRD_W-1])
        begin
            col_idx = '0;
        end
        else if (col_c > {{(CRD_W-COL_W){1'b0}}, cols_m1_reg})
        begin
            col_idx = cols_m1_reg;
        end
        else
        begin
            col_idx = col_c[COL_W-1:0];
        end

        last_t    = (ti_reg == span);
        last_s    = (si_reg == span);
        last_read = last_t && last_s && patch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            patch_reg    <= 1'b0;
            si_reg       <= '0;
            ti_reg       <= '0;
            rd_valid_reg <= 1'b0;
            rd_patch_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= busy_reg;
            rd_patch_reg <= patch_reg;
            rd_last_reg  <= busy_reg && last_read;
            done_reg     <= rd_valid_reg && rd_last_reg;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                patch_reg <= 1'b0;
                si_reg    <= '0;
                ti_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (!last_t)
                begin
                    ti_reg <= ti_reg + SPAN_W'(1);
                end
                else
                begin
                    ti_reg <= '0;
                    if (!last_s)
                    begin
                        si_reg <= si_reg + SPAN_W'(1);
                    end
                    else
                    begin
                        si_reg <= '0;
                        if (patch_reg)
                        begin
                            busy_reg <= 1'b0;
                        end
                        patch_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            min_row_reg <= req.min_row;
            min_col_reg <= req.min_col;
            max_row_reg <= req.max_row;
            max_col_reg <= req.max_col;
            rad_reg     <= req.radius;
            rows_m1_reg <= req.rows_m1;
            cols_m1_reg <= req.cols_m1;
            sum_reg[0]  <= '0;
            sum_reg[1]  <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_reg[rd_patch_reg] <= sum_reg[rd_patch_reg]
                                   + {{(SUM_W-DEPTH_BITS){1'b0}}, rd_data};
        end
    end

    always_comb
    begin
        rsp.rd_en   = busy_reg;
        rsp.rd_addr = {row_idx, col_idx};
        rsp.done    = done_reg;
        rsp.sum_min = sum_reg[0];
        rsp.sum_max = sum_reg[1];
    end

endmodule

### rtl/psre_div.sv
`timescale 1ns / 1ps

module psre_div
    import psre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             zero_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] den_reg;

    logic [SUM_W:0]   shifted;
    logic [SUM_W:0]   diff;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[QUO_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= '0;
                if (req.denom == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            zero_reg <= (req.denom == '0);
            quo_reg  <= (req.denom == '0) ? '0 : {req.numer, {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            den_reg  <= req.denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    always_comb
    begin
        rsp.done         = done_reg;
        rsp.zero_divisor = zero_reg;
        if (quo_reg[QUO_W-1:RATIO_W] != '0)
        begin
            rsp.ratio = '1;
        end
        else
        begin
            rsp.ratio = quo_reg[RATIO_W-1:0];
        end
    end

endmodule

### rtl/patch_sum_ratio_engine.sv
`timescale 1ns / 1ps
// A load request writes one pixel of the depth store.
// A query result is valid after the patch scan of both patches and the divide that follows it;
// the divider finishes at once when the maximum sum is zero.
// The single memory port reads one pixel per cycle and the divider makes one quotient bit per cycle.
// One query is in work at a time; a new request is taken while a result waits in the output register.
// Reset clears control state and sets radius 2 and a 512 x 512 image; the store is not cleared.

module patch_sum_ratio_engine
    import psre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // load_row, load_col, depth_value, min_row, min_col, max_row, max_col, zero fill
    input  logic [79:0]       s_tdata,
    // operation
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // ratio
    output logic [RATIO_W-1:0] m_tdata,
    // zero_divisor
    output logic              m_tuser,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [RAD_W-1:0]   radius_reg;
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    logic               out_valid_reg;
    logic [RATIO_W-1:0] out_ratio_reg;
    logic               out_zero_reg;

    logic [ROW_W-1:0]      load_row;
    logic [COL_W-1:0]      load_col;
    logic [DEPTH_BITS-1:0] depth_value;
    logic [POS_W-1:0]      min_row;
    logic [POS_W-1:0]      min_col;
    logic [POS_W-1:0]      max_row;
    logic [POS_W-1:0]      max_col;

    logic               in_accept;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [DEPTH_BITS-1:0] ram_rdata;
    logic [CFG_W-1:0]   rows_m1;
    logic [CFG_W-1:0]   cols_m1;
    logic [RAD_W-1:0]   radius_eff;
    logic               out_load;

    patch_req_t patch_req;
    patch_rsp_t patch_rsp;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    assign load_row    = s_tdata[8:0];
    assign load_col    = s_tdata[17:9];
    assign depth_value = s_tdata[33:18];
    assign min_row     = s_tdata[43:34];
    assign min_col     = s_tdata[53:44];
    assign max_row     = s_tdata[63:54];
    assign max_col     = s_tdata[73:64];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign ram_we    = in_accept && (s_tuser == OP_LOAD);
    assign ram_addr  = ram_we ? {load_row, load_col} : patch_rsp.rd_addr;

    always_comb
    begin
        if (rows_reg == '0)
        begin
            rows_m1 = '0;
        end
        else if (rows_reg > CFG_W'(MAX_ROWS))
        begin
            rows_m1 = CFG_W'(MAX_ROWS - 1);
        end
        else
        begin
            rows_m1 = rows_reg - CFG_W'(1);
        end

        if (cols_reg == '0)
        begin
            cols_m1 = '0;
        end
        else if (cols_reg > CFG_W'(MAX_COLS))
        begin
            cols_m1 = CFG_W'(MAX_COLS - 1);
        end
        else
        begin
            cols_m1 = cols_reg - CFG_W'(1);
        end

        radius_eff = (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;
    end

    always_comb
    begin
        patch_req.start   = in_accept && (s_tuser == OP_QUERY);
        patch_req.min_row = min_row;
        patch_req.min_col = min_col;
        patch_req.max_row = max_row;
        patch_req.max_col = max_col;
        patch_req.radius  = radius_eff;
        patch_req.rows_m1 = rows_m1[ROW_W-1:0];
        patch_req.cols_m1 = cols_m1[COL_W-1:0];

        div_req.start = patch_rsp.done;
        div_req.numer = patch_rsp.sum_min;
        div_req.denom = patch_rsp.sum_max;
    end

    psre_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (depth_value),
        .rdata (ram_rdata)
    );

    psre_patch u_patch (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (patch_req),
        .rd_data (ram_rdata),
        .rsp     (patch_rsp)
    );

    psre_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == OP_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (patch_rsp.done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            radius_reg    <= RAD_W'(2);
            rows_reg      <= CFG_W'(MAX_ROWS);
            cols_reg      <= CFG_W'(MAX_COLS);
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                    CFG_ROWS:   rows_reg   <= cfg_data;
                    CFG_COLS:   cols_reg   <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ratio_reg <= div_rsp.ratio;
            out_zero_reg  <= div_rsp.zero_divisor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ratio_reg;
    assign m_tuser  = out_zero_reg;

`ifndef ASSERT_OFF
    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !patch_rsp.rd_en)
        else $error("store write while a patch scan is reading");

    a_patch_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        patch_rsp.done |-> (state_reg == ST_SCAN))
        else $error("patch sums finished outside the scan state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not presented after loading the output register");
`endif

endmodule
